// ----- rtl/linear_blend_skinning_defines.svh -----
// Assertion macros of the skinning engine RTL.
// Depends on nothing; included by linear_blend_skinning, which carries assertions.
`ifndef LINEAR_BLEND_SKINNING_DEFINES_SVH
`define LINEAR_BLEND_SKINNING_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("skinning engine check failed");

// Next-cycle implication, checked outside reset.
`define LBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("skinning engine check failed");

`endif

// ----- rtl/lbs_pkg.sv -----
// Constants, types and helpers of the linear blend skinning engine.
// Depends on nothing; used by lbs_palette, linear_blend_skinning and the bench.
package lbs_pkg;

    localparam int JOINTS          = 64;
    localparam int MAX_INFLUENCES  = 8;
    localparam int WORDS_PER_JOINT = 12;
    localparam int PAL_DEPTH       = JOINTS * WORDS_PER_JOINT;
    localparam int PAL_AW          = $clog2(PAL_DEPTH);
    localparam int CNT_W           = $clog2(MAX_INFLUENCES + 1);
    localparam int T_W             = 52;
    localparam int ACC_W           = 64;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_VERTEX = 2'd1;
    localparam logic [1:0] CMD_INFL   = 2'd2;

    typedef logic [PAL_AW-1:0] t_pal_addr;

    typedef struct packed {
        logic        we;
        t_pal_addr   waddr;
        logic [31:0] wdata;
        logic        re;
        t_pal_addr   raddr;
    } t_pal_req;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] res;
        if (x > ACC_W'(64'sh7FFF_FFFF)) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < -ACC_W'(64'sh8000_0000)) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/lbs_palette.sv -----
// Joint matrix palette: single write port, one registered read port.
// Depends on lbs_pkg.
module lbs_palette (
    input  logic              i_clk,
    input  lbs_pkg::t_pal_req i_req,
    output logic [31:0]       o_rdata
);
    import lbs_pkg::*;

    logic [31:0] mem [PAL_DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/linear_blend_skinning.sv -----
// Linear blend skinning engine, top level.
// Depends on lbs_pkg, lbs_palette and linear_blend_skinning_defines.svh.
//
// Usage: one input channel (i_valid / o_stall) carries commands: palette word
// write, vertex start, and influence. One output channel (o_valid / i_stall)
// carries a skinned position and normal for each influence marked last.
// Palette writes, vertex starts, ignored commands and influences that skip
// their joint finish in the idle state; a skipped influence marked last also
// passes the output state. An influence with a palette joint streams its 12
// matrix words from the palette memory through the two 32x32 multipliers,
// then weights the six row sums on one shared multiplier pair, and for the
// last influence the output register is loaded. One transaction is
// processed at a time and o_stall is high while one is in progress and
// during reset.
// The result waits in an output register while the receiver stalls; the
// next transaction is still accepted, and only a new result waits until the
// old one is taken. Reset clears the vertex, the sums and the count; the
// palette is not cleared and must be written before use.
`include "linear_blend_skinning_defines.svh"
module linear_blend_skinning (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [6:0]         i_joint_id,
    input  logic [3:0]         i_word_index,
    input  logic signed [31:0] i_word_value,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_norm_x,
    input  logic signed [31:0] i_norm_y,
    input  logic signed [31:0] i_norm_z,
    input  logic [16:0]        i_weight,
    input  logic               i_last_influence,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_out_nrm_x,
    output logic signed [31:0] o_out_nrm_y,
    output logic signed [31:0] o_out_nrm_z
);
    import lbs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_WGT  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]             r_state;
    logic [CNT_W-1:0]       r_count;
    logic                   r_last;
    logic [16:0]            r_w;
    t_pal_addr              r_base;
    logic signed [31:0]     r_hpos [3];
    logic signed [31:0]     r_hnrm [3];
    logic signed [ACC_W-1:0] r_psum [3];
    logic signed [ACC_W-1:0] r_nsum [3];

    // Matrix stream.
    logic [3:0]             r_k;
    logic [1:0]             r_col, r_row, r_col1, r_row1, r_col2, r_row2;
    logic                   r_v1, r_v2;
    logic signed [31:0]     r_e;
    logic signed [63:0]     r_prod_p, r_prod_n;
    logic signed [T_W-1:0]  r_tp [3];
    logic signed [T_W-1:0]  r_tn [3];

    // Weighting.
    logic [2:0]             r_i;
    logic                   r_wv, r_wnrm;
    logic [1:0]             r_wrow;
    logic [48:0]            r_mlo;
    logic signed [36:0]     r_mhi;

    logic signed [31:0]     r_o [6];
    logic                   r_ovalid;

    t_pal_req               pal_req;
    logic [31:0]            pal_rdata;
    logic                   accept;
    logic                   jid_ok;
    logic signed [31:0]     selp, seln;
    logic signed [T_W-1:0]  tsel;
    logic signed [69:0]     wfull;
    logic signed [ACC_W-1:0] wadd;
    logic                   out_free;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = !i_rst_n || (r_state != S_IDLE);
    assign jid_ok   = (i_joint_id != 7'd0) && (32'(i_joint_id) <= JOINTS);
    assign out_free = !(r_ovalid && i_stall);

    always_comb begin
        pal_req.we    = accept && (i_command == CMD_WRITE) && jid_ok
                        && (32'(i_word_index) < WORDS_PER_JOINT);
        pal_req.waddr = PAL_AW'((32'(i_joint_id) - 1) * WORDS_PER_JOINT
                                + 32'(i_word_index));
        pal_req.wdata = i_word_value;
        pal_req.re    = (r_state == S_MAC) && (r_k < 4'd12);
        pal_req.raddr = r_base + PAL_AW'(r_k);
    end

    lbs_palette u_palette (
        .i_clk   (i_clk),
        .i_req   (pal_req),
        .o_rdata (pal_rdata)
    );

    always_comb begin
        unique case (r_col1)
            2'd0:    begin selp = r_hpos[0]; seln = r_hnrm[0]; end
            2'd1:    begin selp = r_hpos[1]; seln = r_hnrm[1]; end
            2'd2:    begin selp = r_hpos[2]; seln = r_hnrm[2]; end
            default: begin selp = 32'sd0;    seln = 32'sd0;    end
        endcase
        unique case (r_i)
            3'd0:    tsel = r_tp[0];
            3'd1:    tsel = r_tp[1];
            3'd2:    tsel = r_tp[2];
            3'd3:    tsel = r_tn[0];
            3'd4:    tsel = r_tn[1];
            3'd5:    tsel = r_tn[2];
            default: tsel = '0;
        endcase
        // floor(t*w / 2^16) from the split product; the high half is signed.
        wfull = (70'(r_mhi) <<< 32) + signed'(70'(r_mlo));
        wadd  = ACC_W'(wfull >>> 16);
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w    <= i_weight;
            r_last <= i_last_influence;
            r_base <= PAL_AW'((32'(i_joint_id) - 1) * WORDS_PER_JOINT);
        end
        r_col1 <= r_col;
        r_row1 <= r_row;
        if (r_v1) begin
            r_e      <= signed'(pal_rdata);
            r_prod_p <= signed'(pal_rdata) * selp;
            r_prod_n <= signed'(pal_rdata) * seln;
        end
        r_col2 <= r_col1;
        r_row2 <= r_row1;
        if (accept) begin
            for (int r = 0; r < 3; r++) begin
                r_tp[r] <= '0;
                r_tn[r] <= '0;
            end
        end else if (r_v2) begin
            // Column three is the translation and only moves the position.
            if (r_col2 == 2'd3) begin
                r_tp[r_row2] <= r_tp[r_row2] + T_W'(r_e);
            end else begin
                r_tp[r_row2] <= r_tp[r_row2] + T_W'(r_prod_p >>> 16);
                r_tn[r_row2] <= r_tn[r_row2] + T_W'(r_prod_n >>> 16);
            end
        end
        if ((r_state == S_WGT) && (r_i < 3'd6)) begin
            r_mlo  <= 49'(tsel[31:0]) * 49'(r_w);
            r_mhi  <= signed'(tsel[T_W-1:32]) * signed'({1'b0, r_w});
            r_wnrm <= (r_i >= 3'd3);
            r_wrow <= (r_i >= 3'd3) ? 2'(r_i - 3'd3) : r_i[1:0];
        end
        if ((r_state == S_OUT) && out_free) begin
            for (int r = 0; r < 3; r++) begin
                r_o[r]     <= sat32(r_psum[r]);
                r_o[3 + r] <= sat32(r_nsum[r]);
            end
        end
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_k      <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_i      <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_wv     <= 1'b0;
            r_ovalid <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                r_hpos[r] <= '0;
                r_hnrm[r] <= '0;
                r_psum[r] <= '0;
                r_nsum[r] <= '0;
            end
        end else begin
            r_v1 <= pal_req.re;
            r_v2 <= r_v1;
            r_wv <= (r_state == S_WGT) && (r_i < 3'd6);
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_wv) begin
                if (r_wnrm) begin
                    r_nsum[r_wrow] <= r_nsum[r_wrow] + wadd;
                end else begin
                    r_psum[r_wrow] <= r_psum[r_wrow] + wadd;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_command)
                            CMD_VERTEX: begin
                                r_hpos[0] <= i_coord_x;
                                r_hpos[1] <= i_coord_y;
                                r_hpos[2] <= i_coord_z;
                                r_hnrm[0] <= i_norm_x;
                                r_hnrm[1] <= i_norm_y;
                                r_hnrm[2] <= i_norm_z;
                                r_count   <= '0;
                                for (int r = 0; r < 3; r++) begin
                                    r_psum[r] <= '0;
                                    r_nsum[r] <= '0;
                                end
                            end
                            CMD_INFL: begin
                                if (32'(r_count) < MAX_INFLUENCES) begin
                                    r_count <= r_count + 1'b1;
                                    if ((i_joint_id == 7'd0) && (r_count == '0)) begin
                                        for (int r = 0; r < 3; r++) begin
                                            r_psum[r] <= ACC_W'(r_hpos[r]);
                                            r_nsum[r] <= ACC_W'(r_hnrm[r]);
                                        end
                                    end
                                end
                                if ((32'(r_count) < MAX_INFLUENCES) && jid_ok) begin
                                    r_state <= S_MAC;
                                    r_k     <= '0;
                                    r_col   <= '0;
                                    r_row   <= '0;
                                end else if (i_last_influence) begin
                                    r_state <= S_OUT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MAC: begin
                    r_k <= r_k + 4'd1;
                    if (r_row == 2'd2) begin
                        r_row <= '0;
                        r_col <= r_col + 2'd1;
                    end else begin
                        r_row <= r_row + 2'd1;
                    end
                    // The last word leaves the accumulate stage at step 13.
                    if (r_k == 4'd13) begin
                        r_state <= S_WGT;
                        r_i     <= '0;
                    end
                end
                S_WGT: begin
                    r_i <= r_i + 3'd1;
                    if (r_i == 3'd6) begin
                        r_state <= r_last ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_count  <= '0;
                        r_state  <= S_IDLE;
                        for (int r = 0; r < 3; r++) begin
                            r_psum[r] <= '0;
                            r_nsum[r] <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_pos_x = r_o[0];
    assign o_out_pos_y = r_o[1];
    assign o_out_pos_z = r_o[2];
    assign o_out_nrm_x = r_o[3];
    assign o_out_nrm_y = r_o[4];
    assign o_out_nrm_z = r_o[5];

    `LBS_ASSERT_NEXT(a_mac_to_wgt, i_clk, i_rst_n, (r_state == S_MAC) && (r_k == 4'd13), r_state == S_WGT)
    `LBS_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, 32'(r_count) <= MAX_INFLUENCES)
    `LBS_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && out_free, o_valid && (r_count == '0))
    `LBS_ASSERT_NOW(a_read_only_mac, i_clk, i_rst_n, pal_req.re, !pal_req.we && (r_state == S_MAC))

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the linear blend skinning engine: a queued driver,
// an output monitor and a transaction-level predictor of the engine's arithmetic.
// Depends on lbs_pkg and the linear_blend_skinning RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lbs_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct {
        logic [1:0]         command;
        logic [6:0]         joint_id;
        logic [3:0]         word_index;
        logic signed [31:0] word_value;
        logic signed [31:0] coord[3];
        logic signed [31:0] norm[3];
        logic [16:0]        weight;
        logic               last_influence;
        bit                 drain;
    } skin_cmd_t;

    typedef struct packed {
        logic signed [31:0] px, py, pz, nx, ny, nz;
    } skin_out_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_command = '0;
    logic [6:0]         i_joint_id = '0;
    logic [3:0]         i_word_index = '0;
    logic signed [31:0] i_word_value = '0;
    logic signed [31:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic signed [31:0] i_norm_x = '0, i_norm_y = '0, i_norm_z = '0;
    logic [16:0]        i_weight = '0;
    logic               i_last_influence = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [31:0] o_out_nrm_x, o_out_nrm_y, o_out_nrm_z;

    linear_blend_skinning DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    skin_cmd_t pending_cmds[$];
    skin_out_t expected_verts[$];
    skin_cmd_t on_bus;
    bit        took = 1'b0;
    int        mismatches = 0;
    int        cycles = 0;

    // Shadow of the engine state.
    logic signed [31:0] pal_words[PAL_DEPTH];
    logic signed [63:0] held_pos[3], held_nrm[3], pos_acc[3], nrm_acc[3];
    int                 infl_taken = 0;

    function automatic void enqueue(skin_cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [63:0] weighted(logic signed [63:0] t, logic [16:0] w);
        logic signed [127:0] wide;
        wide = t;
        wide = (wide * $signed({1'b0, w})) >>> 16;
        return wide[63:0];
    endfunction

    // Applies one accepted transaction; returns 1 when a vertex is emitted.
    function automatic bit skin_vertex(skin_cmd_t c, output skin_out_t res);
        int base;
        logic signed [63:0] tp, tn, e;
        res = '0;
        case (c.command)
            CMD_WRITE: begin
                if (c.joint_id >= 1 && c.joint_id <= JOINTS && c.word_index < WORDS_PER_JOINT)
                    pal_words[(c.joint_id - 1) * WORDS_PER_JOINT + c.word_index] = c.word_value;
                return 0;
            end
            CMD_VERTEX: begin
                for (int r = 0; r < 3; r++) begin
                    held_pos[r] = c.coord[r];
                    held_nrm[r] = c.norm[r];
                    pos_acc[r] = 0;
                    nrm_acc[r] = 0;
                end
                infl_taken = 0;
                return 0;
            end
            CMD_INFL: begin
                if (infl_taken < MAX_INFLUENCES) begin
                    if (c.joint_id == 0) begin
                        if (infl_taken == 0)
                            for (int r = 0; r < 3; r++) begin
                                pos_acc[r] = held_pos[r];
                                nrm_acc[r] = held_nrm[r];
                            end
                    end else if (c.joint_id <= JOINTS) begin
                        base = (c.joint_id - 1) * WORDS_PER_JOINT;
                        for (int r = 0; r < 3; r++) begin
                            tp = pal_words[base + 9 + r];
                            tn = 0;
                            for (int k = 0; k < 3; k++) begin
                                e = pal_words[base + k * 3 + r];
                                tp += (e * held_pos[k]) >>> 16;
                                tn += (e * held_nrm[k]) >>> 16;
                            end
                            pos_acc[r] += weighted(tp, c.weight);
                            nrm_acc[r] += weighted(tn, c.weight);
                        end
                    end
                    infl_taken++;
                end
                if (!c.last_influence) return 0;
                res = '{clamp32(pos_acc[0]), clamp32(pos_acc[1]), clamp32(pos_acc[2]),
                        clamp32(nrm_acc[0]), clamp32(nrm_acc[1]), clamp32(nrm_acc[2])};
                for (int r = 0; r < 3; r++) begin
                    pos_acc[r] = 0;
                    nrm_acc[r] = 0;
                end
                infl_taken = 0;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // Random Q16.16 value of random magnitude, so both saturation and exact
    // results show up.
    function automatic logic signed [31:0] rnd_q(int mode);
        logic signed [31:0] v;
        v = $urandom;
        case (mode)
            0: return v;
            1: return v >>> $urandom_range(8, 31);
            default: return v >>> $urandom_range(12, 16);
        endcase
    endfunction

    function automatic skin_cmd_t mk(logic [1:0] cmd, logic [6:0] jid, logic [16:0] w,
                                     logic last);
        skin_cmd_t c;
        c.command = cmd;
        c.joint_id = jid;
        c.word_index = 4'($urandom_range(0, 15));
        c.word_value = $urandom;
        for (int r = 0; r < 3; r++) begin
            c.coord[r] = rnd_q($urandom_range(0, 3));
            c.norm[r] = rnd_q($urandom_range(0, 3));
        end
        c.weight = w;
        c.last_influence = last;
        c.drain = 1'b0;
        return c;
    endfunction

    function automatic void add_write(int jid, int wi, logic signed [31:0] val);
        skin_cmd_t c;
        c = mk(CMD_WRITE, 7'(jid), 17'($urandom_range(0, 65536)),
               1'($urandom_range(0, 1)));
        c.word_index = 4'(wi);
        c.word_value = val;
        enqueue(c);
    endfunction

    function automatic void add_vertex(logic signed [31:0] p, logic signed [31:0] n,
                                       bit fixed);
        skin_cmd_t c;
        c = mk(CMD_VERTEX, 7'($urandom_range(0, 127)), 17'($urandom_range(0, 65536)), 1'b0);
        if (fixed)
            for (int r = 0; r < 3; r++) begin
                c.coord[r] = p;
                c.norm[r] = n;
            end
        enqueue(c);
    endfunction

    function automatic void add_infl(int jid, int w, bit last);
        enqueue(mk(CMD_INFL, 7'(jid), 17'(w), last));
    endfunction

    function automatic int rnd_weight();
        case ($urandom_range(0, 5))
            0: return 65536;
            1: return 0;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic int rnd_joint();
        case ($urandom_range(0, 11))
            0: return 0;
            1: return $urandom_range(JOINTS + 1, 127);
            default: return $urandom_range(1, JOINTS);
        endcase
    endfunction

    initial begin
        int n_inf, count;
        for (int i = 0; i < PAL_DEPTH; i++) pal_words[i] = 0;
        for (int r = 0; r < 3; r++) begin
            held_pos[r] = 0; held_nrm[r] = 0; pos_acc[r] = 0; nrm_acc[r] = 0;
        end
        // The whole palette is written first so that no influence reads a
        // word that was never written. Joint 1 is identity with a translation,
        // joints 2 and 3 sit at the extremes.
        for (int j = 1; j <= JOINTS; j++)
            for (int w = 0; w < WORDS_PER_JOINT; w++)
                case (j)
                    1: add_write(j, w, (w == 0 || w == 4 || w == 8) ? 32'sh0001_0000 :
                                       (w >= 9) ? 32'sh0003_8000 : 32'sh0);
                    2: add_write(j, w, 32'sh7FFF_FFFF);
                    3: add_write(j, w, 32'sh8000_0000);
                    default: add_write(j, w, rnd_q($urandom_range(0, 3)));
                endcase
        // Writes that must not land: bad joints and bad word indexes.
        add_write(0, 0, 32'sh1234_5678);
        add_write(JOINTS + 1, 3, 32'sh1234_5678);
        add_write(127, 5, 32'sh1234_5678);
        add_write(1, 12, 32'sh1234_5678);
        add_write(1, 15, 32'sh1234_5678);
        enqueue(mk(CMD_NOP, 7'd5, 17'd100, 1'b1));
        // Result with no vertex given since reset.
        add_infl(5, 65536, 1);
        // Pass-through, extreme vertex.
        add_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1);
        add_infl(0, 1234, 1);
        add_infl(2, 65536, 1);
        add_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
        add_infl(3, 65536, 0);
        add_infl(0, 65536, 0);
        add_infl(JOINTS + 1, 65536, 0);
        add_infl(1, 0, 1);
        add_vertex(0, 0, 0);
        for (int i = 0; i < 10; i++) add_infl(1 + i, 65536, i == 9);
        pending_cmds[pending_cmds.size() - 1].drain = 1'b1;

        // The palette fill above already takes about 800 transactions.
        count = 0;
        while (count < 500) begin
            case ($urandom_range(0, 19))
                0: begin
                    add_write($urandom_range(0, 127), $urandom_range(0, 15),
                              rnd_q($urandom_range(0, 3)));
                    pending_cmds[pending_cmds.size() - 1].joint_id =
                        ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(1, JOINTS));
                    count++;
                end
                1: begin
                    enqueue(mk(CMD_NOP, 7'($urandom_range(0, 127)),
                               17'($urandom_range(0, 131071)), 1'($urandom_range(0, 1))));
                    count++;
                end
                2: begin
                    // Broken sequence: influences without their own vertex.
                    add_infl(rnd_joint(), rnd_weight(), $urandom_range(0, 1));
                    count++;
                end
                default: begin
                    add_vertex(0, 0, 0);
                    n_inf = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12)
                                                        : $urandom_range(1, 4);
                    for (int i = 0; i < n_inf; i++)
                        add_infl((i == 0 && $urandom_range(0, 5) == 0) ? 0 : rnd_joint(),
                                 rnd_weight(), i == n_inf - 1);
                    count += n_inf + 1;
                end
            endcase
            if ($urandom_range(0, 150) == 0)
                pending_cmds[pending_cmds.size() - 1].drain = 1'b1;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_cmds.size() == 0);
        while (i_valid || expected_verts.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_verts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Acceptance, prediction and checking, all at the rising edge.
    always @(posedge i_clk) begin
        skin_out_t res, want;
        cycles <= cycles + 1;
        took = i_rst_n && i_valid && !o_stall;
        if (took && skin_vertex(on_bus, res))
            expected_verts.insert(expected_verts.size(), res);
        if (i_rst_n && o_valid && !i_stall) begin
            res = '{o_out_pos_x, o_out_pos_y, o_out_pos_z,
                    o_out_nrm_x, o_out_nrm_y, o_out_nrm_z};
            if (expected_verts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected vertex %h", res);
            end else begin
                want = expected_verts.pop_front();
                if (res !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Vertex mismatch: expected %h, got %h", want, res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sender in bursts with gaps; payload holds while stalled.
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || took)) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].drain && expected_verts.size() != 0)) begin
                on_bus = pending_cmds.pop_front();
                i_command <= on_bus.command;
                i_joint_id <= on_bus.joint_id;
                i_word_index <= on_bus.word_index;
                i_word_value <= on_bus.word_value;
                i_coord_x <= on_bus.coord[0];
                i_coord_y <= on_bus.coord[1];
                i_coord_z <= on_bus.coord[2];
                i_norm_x <= on_bus.norm[0];
                i_norm_y <= on_bus.norm[1];
                i_norm_z <= on_bus.norm[2];
                i_weight <= on_bus.weight;
                i_last_influence <= on_bus.last_influence;
                i_valid <= 1'b1;
                burst_left--;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: a duty cycle that changes every so often, sometimes off.
    int stall_phase = 0, stall_period = 7, stall_duty = 3, stall_span = 0;
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(50, 400);
            stall_period = $urandom_range(2, 60);
            stall_duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, stall_period - 1);
        end
        stall_span--;
        stall_phase = (stall_phase + 1) % stall_period;
        i_stall <= stall_phase < stall_duty;
    end
endmodule
